[rtl/core/mdfw_pkg.sv]
`default_nettype none

package mdfw_pkg;

    localparam int GRID_SIDE   = 10;
    localparam int STACK_DEPTH = 256;

    localparam int POS_W   = 4;
    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_SIDE - 1);

    // Request kinds.
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_STEP    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Result status codes; ST_WALK doubles as the plain "loaded" answer.
    localparam logic [2:0] ST_WALK   = 3'd0;
    localparam logic [2:0] ST_FWD    = 3'd1;
    localparam logic [2:0] ST_BACK   = 3'd2;
    localparam logic [2:0] ST_GOAL   = 3'd3;
    localparam logic [2:0] ST_BUDGET = 3'd4;
    localparam logic [2:0] ST_TRAP   = 3'd5;

    // Move directions; the opposite direction is the bitwise inverse.
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [7:0] BUDGET_RESET = 8'd200;
    localparam logic [7:0] MOVES_MAX    = 8'd255;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cell_col;
        logic             passage_dir;
        logic             is_wall;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_row;
        logic [POS_W-1:0] pos_col;
        logic [2:0]       status;
        logic [7:0]       moves_done;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] cell_ix;
        logic              pdir;
        logic              wall;
    } mark_load_t;

    typedef struct packed {
        logic       en;
        logic [1:0] dir;
    } mark_take_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [1:0] dir;
    } stack_op_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] top;
    } stack_stat_t;

    function automatic logic dir_in_grid(input logic [POS_W-1:0] row,
                                         input logic [POS_W-1:0] col,
                                         input logic [1:0] dir);
        logic ok;
        begin
            case (dir)
                DIR_RIGHT: ok = (col != LAST_POS);
                DIR_DOWN:  ok = (row != LAST_POS);
                DIR_UP:    ok = (row != '0);
                DIR_LEFT:  ok = (col != '0);
                default:   ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
        return CELL_W'(CELL_W'(row) * CELL_W'(GRID_SIDE) + CELL_W'(col));
    endfunction

endpackage

`default_nettype wire

[rtl/core/maze_depth_first_walker.sv]
// Requests pass through a request register and then a result register.
// Throughput: one request per cycle while the result is not stalled; a new request can
// enter the request register while a finished result waits to be taken.
// All work for a request is one pass of logic on the passage bit planes and the
// direction stack top, between the request register and the result register.
// Reset clears all marks, moves and the stack, homes the walker, sets the budget to 200.
`default_nettype none

module maze_depth_first_walker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire mdfw_pkg::req_t req,
    output logic                res_valid,
    input  wire logic           res_stall,
    output mdfw_pkg::res_t      res,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [7:0]     cfg_data
);
    import mdfw_pkg::*;

    logic             req_valid_reg, req_valid_next;
    req_t             req_reg;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg;
    logic [7:0]       budget_reg;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [7:0]       moves_reg, moves_next;
    logic [2:0]       status_reg, status_next;

    logic             advance;
    logic             accept;
    logic [3:0]       open_dirs;
    logic [1:0]       fwd_dir;
    logic [1:0]       mv_dir;
    logic             mv_en;
    logic [2:0]       mv_kind;
    logic [2:0]       res_status;
    mark_load_t       load;
    mark_take_t       take;
    logic             clear_trail;
    stack_op_t        sop;
    stack_stat_t      sstat;

    assign advance   = req_valid_reg && !(res_valid_reg && res_stall);
    assign req_stall = req_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    mdfw_marks u_marks (
        .clk         (clk),
        .rst_n       (rst_n),
        .pos_row     (row_reg),
        .pos_col     (col_reg),
        .load        (load),
        .take        (take),
        .clear_trail (clear_trail),
        .open_dirs   (open_dirs)
    );

    mdfw_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (sop),
        .stat  (sstat)
    );

    always_comb
    begin
        if (open_dirs[DIR_RIGHT])
        begin
            fwd_dir = DIR_RIGHT;
        end
        else if (open_dirs[DIR_DOWN])
        begin
            fwd_dir = DIR_DOWN;
        end
        else if (open_dirs[DIR_UP])
        begin
            fwd_dir = DIR_UP;
        end
        else
        begin
            fwd_dir = DIR_LEFT;
        end
    end

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        moves_next  = moves_reg;
        status_next = status_reg;
        res_status  = ST_WALK;
        load        = '0;
        take        = '0;
        clear_trail = 1'b0;
        sop         = '0;
        mv_dir      = fwd_dir;
        mv_en       = 1'b0;
        mv_kind     = ST_FWD;
        if (advance)
        begin
            case (req_reg.kind)
                KIND_LOAD:
                begin
                    if (({1'b0, req_reg.cell_row} < (POS_W + 1)'(GRID_SIDE)) &&
                        ({1'b0, req_reg.cell_col} < (POS_W + 1)'(GRID_SIDE)))
                    begin
                        load.en      = 1'b1;
                        load.cell_ix = cell_index(req_reg.cell_row, req_reg.cell_col);
                        load.pdir    = req_reg.passage_dir;
                        load.wall    = req_reg.is_wall;
                    end
                end
                KIND_STEP:
                begin
                    if (status_reg != ST_WALK)
                    begin
                        res_status = status_reg;
                    end
                    else if (row_reg == LAST_POS && col_reg == LAST_POS)
                    begin
                        status_next = ST_GOAL;
                        res_status  = ST_GOAL;
                    end
                    else if (moves_reg >= budget_reg)
                    begin
                        status_next = ST_BUDGET;
                        res_status  = ST_BUDGET;
                    end
                    else if (open_dirs != '0)
                    begin
                        take.en  = 1'b1;
                        take.dir = fwd_dir;
                        sop.push = 1'b1;
                        sop.dir  = fwd_dir;
                        mv_dir   = fwd_dir;
                        mv_en    = 1'b1;
                        mv_kind  = ST_FWD;
                    end
                    else if (sstat.empty)
                    begin
                        status_next = ST_TRAP;
                        res_status  = ST_TRAP;
                    end
                    else
                    begin
                        sop.pop = 1'b1;
                        mv_dir  = ~sstat.top;
                        mv_en   = 1'b1;
                        mv_kind = ST_BACK;
                    end
                end
                KIND_RESTART:
                begin
                    clear_trail = 1'b1;
                    sop.clear   = 1'b1;
                    row_next    = '0;
                    col_next    = '0;
                    moves_next  = '0;
                    status_next = ST_WALK;
                end
                default:
                begin
                end
            endcase
        end

        // A back move through the grid border is counted but not made.
        if (mv_en)
        begin
            if (dir_in_grid(row_reg, col_reg, mv_dir))
            begin
                case (mv_dir)
                    DIR_RIGHT: col_next = col_reg + POS_W'(1);
                    DIR_DOWN:  row_next = row_reg + POS_W'(1);
                    DIR_UP:    row_next = row_reg - POS_W'(1);
                    DIR_LEFT:  col_next = col_reg - POS_W'(1);
                    default:   col_next = col_reg;
                endcase
            end
            if (moves_reg != MOVES_MAX)
            begin
                moves_next = moves_reg + 8'd1;
            end
            if (moves_next >= budget_reg)
            begin
                status_next = ST_BUDGET;
            end
            else if (row_next == LAST_POS && col_next == LAST_POS)
            begin
                status_next = ST_GOAL;
            end
            res_status = (status_next != ST_WALK) ? status_next : mv_kind;
        end
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            res_reg.pos_row    <= row_next;
            res_reg.pos_col    <= col_next;
            res_reg.status     <= res_status;
            res_reg.moves_done <= moves_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            budget_reg    <= BUDGET_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            moves_reg     <= '0;
            status_reg    <= ST_WALK;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                budget_reg <= cfg_data;
            end
            row_reg    <= row_next;
            col_reg    <= col_next;
            moves_reg  <= moves_next;
            status_reg <= status_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[rtl/core/mdfw_marks.sv]
`default_nettype none

module mdfw_marks (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [mdfw_pkg::POS_W-1:0] pos_row,
    input  wire logic [mdfw_pkg::POS_W-1:0] pos_col,
    input  wire mdfw_pkg::mark_load_t      load,
    input  wire mdfw_pkg::mark_take_t      take,
    input  wire logic                      clear_trail,
    output logic [3:0]                     open_dirs
);
    import mdfw_pkg::*;

    // One bit per cell for the right passage and one for the lower passage.
    logic [CELLS-1:0] wall_r_reg, wall_r_next;
    logic [CELLS-1:0] wall_d_reg, wall_d_next;
    logic [CELLS-1:0] trail_r_reg, trail_r_next;
    logic [CELLS-1:0] trail_d_reg, trail_d_next;

    logic [CELL_W-1:0] cur_cell;
    logic [CELL_W-1:0] up_cell;
    logic [CELL_W-1:0] left_cell;
    logic [CELL_W-1:0] take_cell;
    logic              take_down;

    assign cur_cell  = cell_index(pos_row, pos_col);
    assign up_cell   = CELL_W'(cur_cell - CELL_W'(GRID_SIDE));
    assign left_cell = CELL_W'(cur_cell - CELL_W'(1));

    // A border passage is never read, so its wrapped index does not matter.
    always_comb
    begin
        open_dirs[DIR_RIGHT] = dir_in_grid(pos_row, pos_col, DIR_RIGHT) ?
                               !(wall_r_reg[cur_cell] || trail_r_reg[cur_cell]) : 1'b0;
        open_dirs[DIR_DOWN]  = dir_in_grid(pos_row, pos_col, DIR_DOWN) ?
                               !(wall_d_reg[cur_cell] || trail_d_reg[cur_cell]) : 1'b0;
        open_dirs[DIR_UP]    = dir_in_grid(pos_row, pos_col, DIR_UP) ?
                               !(wall_d_reg[up_cell] || trail_d_reg[up_cell]) : 1'b0;
        open_dirs[DIR_LEFT]  = dir_in_grid(pos_row, pos_col, DIR_LEFT) ?
                               !(wall_r_reg[left_cell] || trail_r_reg[left_cell]) : 1'b0;
    end

    always_comb
    begin
        case (take.dir)
            DIR_RIGHT:
            begin
                take_cell = cur_cell;
                take_down = 1'b0;
            end
            DIR_DOWN:
            begin
                take_cell = cur_cell;
                take_down = 1'b1;
            end
            DIR_UP:
            begin
                take_cell = up_cell;
                take_down = 1'b1;
            end
            DIR_LEFT:
            begin
                take_cell = left_cell;
                take_down = 1'b0;
            end
            default:
            begin
                take_cell = cur_cell;
                take_down = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wall_r_next  = wall_r_reg;
        wall_d_next  = wall_d_reg;
        trail_r_next = trail_r_reg;
        trail_d_next = trail_d_reg;
        if (clear_trail)
        begin
            trail_r_next = '0;
            trail_d_next = '0;
        end
        // A load overwrites the whole mark, so it also drops any trail.
        if (load.en)
        begin
            if (load.pdir)
            begin
                wall_d_next[load.cell_ix]  = load.wall;
                trail_d_next[load.cell_ix] = 1'b0;
            end
            else
            begin
                wall_r_next[load.cell_ix]  = load.wall;
                trail_r_next[load.cell_ix] = 1'b0;
            end
        end
        if (take.en)
        begin
            if (take_down)
            begin
                trail_d_next[take_cell] = 1'b1;
            end
            else
            begin
                trail_r_next[take_cell] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_r_reg  <= '0;
            wall_d_reg  <= '0;
            trail_r_reg <= '0;
            trail_d_reg <= '0;
        end
        else
        begin
            wall_r_reg  <= wall_r_next;
            wall_d_reg  <= wall_d_next;
            trail_r_reg <= trail_r_next;
            trail_d_reg <= trail_d_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mdfw_stack.sv]
`default_nettype none

module mdfw_stack (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mdfw_pkg::stack_op_t   op,
    output mdfw_pkg::stack_stat_t      stat
);
    import mdfw_pkg::*;

    // The newest entry lives in top_reg; older entries live in the memory,
    // and the one just below the top is kept read out ahead of time.
    logic [1:0]         mem [STACK_DEPTH];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         top_reg, top_next;
    logic [1:0]         rd_reg;
    logic               byp_reg;
    logic [1:0]         byp_data_reg;
    logic [1:0]         below;
    logic               full;
    logic               do_push;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    assign full    = (count_reg == COUNT_W'(STACK_DEPTH));
    assign do_push = op.push && !full;
    assign wr_en   = do_push && (count_reg != '0);
    assign wr_addr = ADDR_W'(count_reg - COUNT_W'(1));
    assign below   = byp_reg ? byp_data_reg : rd_reg;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (op.clear)
        begin
            count_next = '0;
        end
        else if (do_push)
        begin
            count_next = COUNT_W'(count_reg + COUNT_W'(1));
            top_next   = op.dir;
        end
        else if (op.pop)
        begin
            count_next = COUNT_W'(count_reg - COUNT_W'(1));
            top_next   = below;
        end
    end

    assign rd_addr = ADDR_W'(count_next - COUNT_W'(2));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        rd_reg       <= mem[rd_addr];
        byp_data_reg <= top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            top_reg   <= DIR_RIGHT;
            byp_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            top_reg   <= top_next;
            byp_reg   <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = full;
    assign stat.top   = top_reg;

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (op.pop && !op.clear && !op.push) |-> (count_reg != '0))
        else $error("stack popped while empty");

    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        (op.push && !op.clear && !full) |=> (top_reg == $past(op.dir)))
        else $error("pushed direction not on top");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op.push && !op.clear && !full) |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("push did not grow the stack");

endmodule

`default_nettype wire
